@@ hw/rtl/chavg_pkg.sv @@
// ----------------------------------------------------------------------------
// Colour history averaging - shared package
// Widths, reset values and register indexes used across the block.
// ----------------------------------------------------------------------------
package chavg_pkg;

	// Default number of history entries the memory is sized for.
	localparam int MAX_HISTORY_DEF = 32;

	// Width of one colour channel.
	localparam int CH_W = 8;

	// Width of one stored RGB entry.
	localparam int COLOR_W = 3 * CH_W;

	// Configuration register width and index width.
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_RUN_THRESHOLD = 2'd1;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RST       = 6'd20;
	localparam logic [CFG_DATA_W-1:0] BLACK_RUN_THRESHOLD_RST = 6'd5;

endpackage

@@ hw/rtl/chavg_if.sv @@
// ----------------------------------------------------------------------------
// Colour history averaging - channel interfaces
// Valid/ready channels for the picked colour, the averaged result and the
// configuration writes.
// ----------------------------------------------------------------------------
interface chavg_pick_if import chavg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] new_red;
	logic [CH_W-1:0] new_green;
	logic [CH_W-1:0] new_blue;
	logic [CH_W-1:0] new_alpha;

	modport source (output valid, new_red, new_green, new_blue, new_alpha, input ready);
	modport sink   (input valid, new_red, new_green, new_blue, new_alpha, output ready);
endinterface

interface chavg_avg_if import chavg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] avg_red;
	logic [CH_W-1:0] avg_green;
	logic [CH_W-1:0] avg_blue;
	logic [CH_W-1:0] avg_alpha;

	modport source (output valid, avg_red, avg_green, avg_blue, avg_alpha, input ready);
	modport sink   (input valid, avg_red, avg_green, avg_blue, avg_alpha, output ready);
endinterface

interface chavg_cfg_if import chavg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/chavg_ram.sv @@
// ----------------------------------------------------------------------------
// Colour history averaging - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module chavg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/chavg_scan.sv @@
// ----------------------------------------------------------------------------
// Colour history averaging - history walk
// Reads the history newest first, one entry a cycle, and accumulates the
// channel sums and the divisor count with the black run rule.
// ----------------------------------------------------------------------------
module chavg_scan import chavg_pkg::*; #(
	parameter int MAX_HISTORY = MAX_HISTORY_DEF,
	localparam int AW   = $clog2(MAX_HISTORY),
	localparam int CW   = $clog2(MAX_HISTORY + 1),
	localparam int SW   = CH_W + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [AW-1:0]         head,
	input  logic [CW-1:0]         fill,
	input  logic [CFG_DATA_W-1:0] thresh,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  logic [COLOR_W-1:0]    rd_data,
	output logic                  done,
	output logic [SW-1:0]         sum_red,
	output logic [SW-1:0]         sum_green,
	output logic [SW-1:0]         sum_blue,
	output logic [CW-1:0]         count
);

	localparam int CMPW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	logic          busy_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] left_q;
	logic          vld_s1;
	logic          last_s1;
	logic          done_q;
	logic [CW-1:0] run_q, run_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [SW-1:0] sr_q, sg_q, sb_q;
	logic [SW-1:0] sr_n, sg_n, sb_n;
	logic [CW-1:0] run_bonus;
	logic [CW-1:0] tail_bonus;

	assign rd_en   = busy_q;
	assign rd_addr = addr_q;

	// A run that has just ended counts only when it is longer than the threshold.
	assign run_bonus = (CMPW'(run_q) > CMPW'(thresh)) ? run_q : '0;

	always_comb begin
		run_n = run_q;
		cnt_n = cnt_q;
		sr_n  = sr_q;
		sg_n  = sg_q;
		sb_n  = sb_q;
		if (vld_s1) begin
			if (rd_data == '0) begin
				run_n = run_q + CW'(1);
			end else begin
				run_n = '0;
				cnt_n = cnt_q + run_bonus + CW'(1);
				sr_n  = sr_q + SW'(rd_data[3*CH_W-1:2*CH_W]);
				sg_n  = sg_q + SW'(rd_data[2*CH_W-1:CH_W]);
				sb_n  = sb_q + SW'(rd_data[CH_W-1:0]);
			end
		end
	end

	// The run still open at the oldest entry is judged the same way.
	assign tail_bonus = (CMPW'(run_n) > CMPW'(thresh)) ? run_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (left_q == CW'(1));
			done_q  <= vld_s1 && last_s1;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (left_q == CW'(1))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= head;
			left_q <= fill;
			run_q  <= '0;
			cnt_q  <= '0;
			sr_q   <= '0;
			sg_q   <= '0;
			sb_q   <= '0;
		end else begin
			if (busy_q) begin
				addr_q <= (addr_q == '0) ? AW'(MAX_HISTORY - 1) : addr_q - AW'(1);
				left_q <= left_q - CW'(1);
			end
			run_q <= run_n;
			sr_q  <= sr_n;
			sg_q  <= sg_n;
			sb_q  <= sb_n;
			cnt_q <= (vld_s1 && last_s1) ? cnt_n + tail_bonus : cnt_n;
		end
	end

	assign done      = done_q;
	assign sum_red   = sr_q;
	assign sum_green = sg_q;
	assign sum_blue  = sb_q;
	assign count     = cnt_q;

endmodule

@@ hw/rtl/chavg_div.sv @@
// ----------------------------------------------------------------------------
// Colour history averaging - channel divider
// Restoring division of three sums by one count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module chavg_div import chavg_pkg::*; #(
	parameter int SW = 14,
	parameter int CW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SW-1:0]   num_red,
	input  logic [SW-1:0]   num_green,
	input  logic [SW-1:0]   num_blue,
	input  logic [CW-1:0]   den,
	output logic            done,
	output logic [CH_W-1:0] quo_red,
	output logic [CH_W-1:0] quo_green,
	output logic [CH_W-1:0] quo_blue
);

	localparam int SCW = $clog2(SW + 1);
	localparam int RW  = CW + 1;

	logic           busy_q;
	logic           done_q;
	logic [SCW-1:0] step_q;
	logic [CW-1:0]  den_q;
	logic [SW-1:0]  dvd_q [3];
	logic [CW-1:0]  rem_q [3];
	logic [SW-1:0]  dvd_n [3];
	logic [CW-1:0]  rem_n [3];
	logic [RW-1:0]  rem_sh [3];

	// Each lane shifts the quotient bits into the dividend register.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem_sh[k] = {rem_q[k], dvd_q[k][SW-1]};
			if (rem_sh[k] >= RW'(den_q)) begin
				rem_n[k] = CW'(rem_sh[k] - RW'(den_q));
				dvd_n[k] = {dvd_q[k][SW-2:0], 1'b1};
			end else begin
				rem_n[k] = rem_sh[k][CW-1:0];
				dvd_n[k] = {dvd_q[k][SW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == SCW'(SW - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SCW'(1);
				if (step_q == SCW'(SW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q    <= den;
			dvd_q[0] <= num_red;
			dvd_q[1] <= num_green;
			dvd_q[2] <= num_blue;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= '0;
			end
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				dvd_q[k] <= dvd_n[k];
				rem_q[k] <= rem_n[k];
			end
		end
	end

	// A zero count gives black.
	assign quo_red   = (den_q == '0) ? '0 : dvd_q[0][CH_W-1:0];
	assign quo_green = (den_q == '0) ? '0 : dvd_q[1][CH_W-1:0];
	assign quo_blue  = (den_q == '0) ? '0 : dvd_q[2][CH_W-1:0];
	assign done      = done_q;

endmodule

@@ hw/rtl/color_history_average_core.sv @@
// ----------------------------------------------------------------------------
// Colour history averaging - top level
// Keeps the newest picked colours in a ring buffer and returns the average
// colour over the history, with black runs counted by a threshold rule.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Handshake      Payload
//  pick_ch   sink    valid/ready    new_red, new_green, new_blue, new_alpha
//  avg_ch    source  valid/ready    avg_red, avg_green, avg_blue, avg_alpha
//  cfg_ch    sink    valid/ready    index, data (always ready)
//
//  For each item the history walk reads fill entries, fill being the history
//  occupancy after the item (at most the window), and the divider forms SW
//  quotient bits, SW being the sum width (CH_W plus the count width, 14 for
//  32 entries). The walk is bound by the single read port of the ring buffer,
//  one entry a cycle; the divider retires one quotient bit a cycle.
//  Reset clears the fill count, ring pointer and state and sets the registers
//  to defaults; the ring buffer is not cleared, as only written entries are read.
//  A result waiting on avg_ch does not block the next item; only a second
//  finished result stalls the block until the first one is taken.
//
module color_history_average_core import chavg_pkg::*; #(
	parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	chavg_pick_if.sink  pick_ch,
	chavg_avg_if.source avg_ch,
	chavg_cfg_if.sink   cfg_ch
);

	localparam int AW = $clog2(MAX_HISTORY);
	localparam int CW = $clog2(MAX_HISTORY + 1);
	localparam int SW = CH_W + CW;
	// Common width for comparing the fill count with configuration values.
	localparam int WW = (CW > CFG_DATA_W + 1) ? CW : CFG_DATA_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0] window_q;
	logic [CFG_DATA_W-1:0] thresh_q;
	logic [AW-1:0]         head_q, head_n;
	logic [CW-1:0]         fill_q, fill_n;
	logic [CH_W-1:0]       alpha_q;
	logic [WW-1:0]         win_eff;
	logic [WW-1:0]         fill_inc;
	logic                  pick_acc;
	logic                  avg_free;
	logic                  avg_load;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [COLOR_W-1:0]    rd_data;
	logic                  scan_done;
	logic [SW-1:0]         sum_red, sum_green, sum_blue;
	logic [CW-1:0]         count;
	logic                  div_done;
	logic [CH_W-1:0]       quo_red, quo_green, quo_blue;

	logic                  avg_valid_q;
	logic [CH_W-1:0]       avg_red_q, avg_green_q, avg_blue_q, avg_alpha_q;

	// Configuration writes are taken at any time; the user writes only while idle.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_LENGTH_RST;
			thresh_q <= BLACK_RUN_THRESHOLD_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_WINDOW_LENGTH:       window_q <= cfg_ch.data;
				REG_BLACK_RUN_THRESHOLD: thresh_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// The effective window is clamped to between one and the buffer depth.
	always_comb begin
		if (window_q == '0) begin
			win_eff = WW'(1);
		end else if (WW'(window_q) > WW'(MAX_HISTORY)) begin
			win_eff = WW'(MAX_HISTORY);
		end else begin
			win_eff = WW'(window_q);
		end
	end

	// The fill count follows a shrunk window at once, dropping the oldest entries.
	assign fill_inc = WW'(fill_q) + WW'(1);
	assign fill_n   = (fill_inc < win_eff) ? CW'(fill_inc) : CW'(win_eff);
	assign head_n   = (head_q == AW'(MAX_HISTORY - 1)) ? '0 : head_q + AW'(1);

	assign pick_ch.ready = (state_q == ST_IDLE);
	assign pick_acc      = pick_ch.valid && pick_ch.ready;
	assign avg_free      = !avg_valid_q || avg_ch.ready;
	// A finished result moves into the output register once that is free.
	assign avg_load      = ((state_q == ST_DIV && div_done) || state_q == ST_HOLD) && avg_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fill_q  <= '0;
		end else if (pick_acc) begin
			head_q <= head_n;
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pick_acc) begin
			alpha_q <= pick_ch.new_alpha;
		end
	end

	// The newest colour is written at the new head; the walk first reads there
	// in the cycle after the write, so the buffer already holds it.
	chavg_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (MAX_HISTORY)
	) u_ram (
		.clk   (clk),
		.we    (pick_acc),
		.waddr (head_n),
		.wdata ({pick_ch.new_red, pick_ch.new_green, pick_ch.new_blue}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	chavg_scan #(
		.MAX_HISTORY (MAX_HISTORY)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pick_acc),
		.head      (head_n),
		.fill      (fill_n),
		.thresh    (thresh_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.done      (scan_done),
		.sum_red   (sum_red),
		.sum_green (sum_green),
		.sum_blue  (sum_blue),
		.count     (count)
	);

	chavg_div #(
		.SW (SW),
		.CW (CW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_done),
		.num_red   (sum_red),
		.num_green (sum_green),
		.num_blue  (sum_blue),
		.den       (count),
		.done      (div_done),
		.quo_red   (quo_red),
		.quo_green (quo_green),
		.quo_blue  (quo_blue)
	);

	// Sequencer: walk, divide, then hand over to the output register. The
	// quotients stay put in the divider while a result waits in HOLD.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_valid_q <= 1'b0;
		end else begin
			if (avg_load) begin
				avg_valid_q <= 1'b1;
			end else if (avg_valid_q && avg_ch.ready) begin
				avg_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (pick_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV, ST_HOLD: begin
					if (avg_load) begin
						state_q <= ST_IDLE;
					end else if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (avg_load) begin
			avg_red_q   <= quo_red;
			avg_green_q <= quo_green;
			avg_blue_q  <= quo_blue;
			avg_alpha_q <= alpha_q;
		end
	end

	assign avg_ch.valid     = avg_valid_q;
	assign avg_ch.avg_red   = avg_red_q;
	assign avg_ch.avg_green = avg_green_q;
	assign avg_ch.avg_blue  = avg_blue_q;
	assign avg_ch.avg_alpha = avg_alpha_q;

	// The walk finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_SCAN))
		else $error("history walk finished outside the scan phase");

	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	// After an accepted item the history holds at least that item, and never
	// more entries than the buffer has.
	assert property (@(posedge clk) disable iff (!arst_n)
		pick_acc |=> (fill_q != '0) && (WW'(fill_q) <= WW'(MAX_HISTORY)))
		else $error("fill count out of range after an item");

	// A waiting result is not overwritten by the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(avg_valid_q && !avg_ch.ready) |=> avg_valid_q && $stable(avg_red_q)
			&& $stable(avg_green_q) && $stable(avg_blue_q) && $stable(avg_alpha_q))
		else $error("pending result changed before it was taken");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour history averaging - testbench
// Drives picked colours into the core with bursty input and a stalling
// output, predicts every averaged colour from a local copy of the history
// and compares each result field by field, across several register settings.
// ----------------------------------------------------------------------------
module tb;
	import chavg_pkg::*;

	// One colour item, as sent and as returned.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} rgba_t;

	logic clk;
	logic arst_n;

	chavg_pick_if pick_ch();
	chavg_avg_if  avg_ch();
	chavg_cfg_if  cfg_ch();

	color_history_average_core #(
		.MAX_HISTORY(MAX_HISTORY_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pick_ch(pick_ch),
		.avg_ch (avg_ch),
		.cfg_ch (cfg_ch)
	);

	// Our own view of the block: the history (entry 0 newest), how many
	// entries are valid, and the two registers as last written.
	logic [COLOR_W-1:0]    hist_rgb [MAX_HISTORY_DEF];
	int unsigned           hist_fill;
	logic [CFG_DATA_W-1:0] window_reg;
	logic [CFG_DATA_W-1:0] black_thr_reg;

	// Averaged colours that are owed by the block, oldest first.
	rgba_t pending_avgs[$];

	int unsigned mismatches;

	// Sender and receiver pacing. A steady flag switches idling off on that
	// side, so that some stretches run at full rate.
	int unsigned burst_left;
	bit          tx_steady;
	bit          rx_steady;
	bit          rx_on;
	int unsigned rx_seg_left;

	// Length of the black run still to be sent by the random generator.
	int unsigned black_run_left;

	// The clock runs for the whole simulation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the run. The slowest legal run is around two million
	// nanoseconds, so this leaves a wide margin.
	initial begin
		#12_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Shifts the new colour into the history and returns the average that the
	// block should produce for it. The scan runs from newest to oldest. Each
	// non-black entry adds to the sums and counts once; a maximal run of black
	// entries counts with its length only if it is longer than the threshold.
	function automatic rgba_t average_with(input rgba_t px);
		int unsigned        eff_win;
		int unsigned        cnt;
		int unsigned        run;
		int unsigned        sum_r;
		int unsigned        sum_g;
		int unsigned        sum_b;
		int unsigned        i;
		logic [COLOR_W-1:0] c;
		rgba_t              res;
		// A window of zero behaves as one, anything above the history size as
		// the full history.
		if (window_reg == '0)
			eff_win = 1;
		else if (window_reg > MAX_HISTORY_DEF)
			eff_win = MAX_HISTORY_DEF;
		else
			eff_win = window_reg;
		for (i = MAX_HISTORY_DEF - 1; i > 0; i--)
			hist_rgb[i] = hist_rgb[i - 1];
		hist_rgb[0] = {px.red, px.green, px.blue};
		// A shrunk window drops the older entries at once.
		hist_fill = (hist_fill + 1 < eff_win) ? hist_fill + 1 : eff_win;
		cnt   = 0;
		run   = 0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (i = 0; i < hist_fill; i++) begin
			c = hist_rgb[i];
			if (c == '0) begin
				run++;
			end else begin
				if (run > black_thr_reg)
					cnt += run;
				run = 0;
				sum_r += c[2*CH_W +: CH_W];
				sum_g += c[CH_W +: CH_W];
				sum_b += c[0 +: CH_W];
				cnt++;
			end
		end
		if (run > black_thr_reg)
			cnt += run;
		res.alpha = px.alpha;
		if (cnt != 0) begin
			res.red   = CH_W'(sum_r / cnt);
			res.green = CH_W'(sum_g / cnt);
			res.blue  = CH_W'(sum_b / cnt);
		end else begin
			// Nothing counted: the colour is black, the alpha still passes.
			res.red   = '0;
			res.green = '0;
			res.blue  = '0;
		end
		return res;
	endfunction

	function automatic rgba_t rgba(input int r, input int g, input int b, input int a);
		rgba_t px;
		px.red   = CH_W'(r);
		px.green = CH_W'(g);
		px.blue  = CH_W'(b);
		px.alpha = CH_W'(a);
		return px;
	endfunction

	// Random colours shaped so that black runs of lengths around the
	// threshold turn up often; the rest are a mix of full range, saturated,
	// nearly black and bright colours.
	function automatic rgba_t next_random_colour();
		rgba_t       px;
		int unsigned lo;
		px.alpha = CH_W'($urandom_range(0, 255));
		if (black_run_left == 0 && $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1)) begin
				lo = (black_thr_reg > 1) ? black_thr_reg - 1 : 1;
				black_run_left = $urandom_range(lo, black_thr_reg + 2);
			end else begin
				black_run_left = $urandom_range(1, 6);
			end
		end
		if (black_run_left != 0) begin
			black_run_left--;
			px.red   = '0;
			px.green = '0;
			px.blue  = '0;
			return px;
		end
		case ($urandom_range(0, 3))
			0: begin
				{px.red, px.green, px.blue} = COLOR_W'($urandom());
			end
			1: begin
				px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			2: begin
				// Only one channel lit, and only faintly.
				px.red   = '0;
				px.green = '0;
				px.blue  = '0;
				case ($urandom_range(0, 2))
					0: px.red   = CH_W'($urandom_range(1, 3));
					1: px.green = CH_W'($urandom_range(1, 3));
					default: px.blue = CH_W'($urandom_range(1, 3));
				endcase
			end
			default: begin
				px.red   = CH_W'($urandom_range(192, 255));
				px.green = CH_W'($urandom_range(192, 255));
				px.blue  = CH_W'($urandom_range(192, 255));
			end
		endcase
		if ({px.red, px.green, px.blue} == '0)
			px.blue = CH_W'(1);
		return px;
	endfunction

	// Sends one colour and records its expected average once the block has
	// taken it. Must be called just after a rising edge. Valid stays high
	// between items of a burst and only drops for a gap.
	task automatic send_colour(input rgba_t px);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = tx_steady ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				pick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pick_ch.valid     <= 1'b1;
		pick_ch.new_red   <= px.red;
		pick_ch.new_green <= px.green;
		pick_ch.new_blue  <= px.blue;
		pick_ch.new_alpha <= px.alpha;
		do @(posedge clk); while (!pick_ch.ready);
		pending_avgs.push_back(average_with(px));
	endtask

	// Registers only change with the block idle: input stopped and every
	// owed result collected, plus a few cycles for good measure.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
	                              input logic [CFG_DATA_W-1:0] value);
		pick_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_avgs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_WINDOW_LENGTH)
			window_reg = value;
		else if (idx == REG_BLACK_RUN_THRESHOLD)
			black_thr_reg = value;
	endtask

	// Receiver: drives ready on a pattern of its own and checks each result
	// taken against the oldest expectation.
	always @(posedge clk) begin
		rgba_t want;
		if (rx_steady) begin
			avg_ch.ready <= 1'b1;
		end else begin
			if (rx_seg_left == 0) begin
				rx_on = !rx_on;
				rx_seg_left = rx_on ? $urandom_range(1, 16) : $urandom_range(1, 24);
			end
			rx_seg_left--;
			avg_ch.ready <= rx_on;
		end
		if (arst_n && avg_ch.valid && avg_ch.ready) begin
			if (pending_avgs.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = pending_avgs.pop_front();
				if (avg_ch.avg_red !== want.red)
					report_mismatch($sformatf("avg_red got %0d want %0d",
						avg_ch.avg_red, want.red));
				if (avg_ch.avg_green !== want.green)
					report_mismatch($sformatf("avg_green got %0d want %0d",
						avg_ch.avg_green, want.green));
				if (avg_ch.avg_blue !== want.blue)
					report_mismatch($sformatf("avg_blue got %0d want %0d",
						avg_ch.avg_blue, want.blue));
				if (avg_ch.avg_alpha !== want.alpha)
					report_mismatch($sformatf("avg_alpha got %0d want %0d",
						avg_ch.avg_alpha, want.alpha));
			end
		end
	end

	// Field extremes at the reset settings: full white, black behind a
	// coloured entry, single saturated channels and the faintest grey.
	task automatic test_channel_extremes();
		send_colour(rgba(255, 255, 255, 255));
		send_colour(rgba(0, 0, 0, 0));
		send_colour(rgba(255, 0, 0, 128));
		send_colour(rgba(0, 255, 0, 1));
		send_colour(rgba(0, 0, 255, 254));
		send_colour(rgba(1, 1, 1, 127));
	endtask

	// Shrinking the window to two drops the older entries straight away;
	// two blacks then leave nothing counted, so the result is black.
	task automatic test_zero_count();
		write_register(REG_WINDOW_LENGTH, 6'd2);
		send_colour(rgba(0, 0, 0, 77));
		send_colour(rgba(0, 0, 0, 200));
	endtask

	// Black runs around the threshold: with a threshold of zero any run
	// counts; with two, a run of three does and shorter ones do not.
	task automatic test_black_runs();
		write_register(REG_WINDOW_LENGTH, 6'd8);
		write_register(REG_BLACK_RUN_THRESHOLD, 6'd0);
		send_colour(rgba(200, 100, 50, 9));
		send_colour(rgba(0, 0, 0, 10));
		write_register(REG_BLACK_RUN_THRESHOLD, 6'd2);
		send_colour(rgba(90, 90, 90, 11));
		send_colour(rgba(0, 0, 0, 12));
		send_colour(rgba(0, 0, 0, 13));
		send_colour(rgba(0, 0, 0, 14));
		send_colour(rgba(30, 60, 90, 15));
	endtask

	// A window of zero acts as one, the largest value as the full history,
	// and a threshold beyond the window means black never counts.
	task automatic test_window_limits();
		write_register(REG_WINDOW_LENGTH, 6'd0);
		send_colour(rgba(10, 20, 30, 40));
		send_colour(rgba(40, 50, 60, 70));
		write_register(REG_WINDOW_LENGTH, 6'd63);
		write_register(REG_BLACK_RUN_THRESHOLD, 6'd63);
		send_colour(rgba(0, 0, 0, 1));
		send_colour(rgba(0, 0, 0, 2));
		send_colour(rgba(0, 0, 0, 3));
		send_colour(rgba(17, 0, 255, 4));
		write_register(REG_WINDOW_LENGTH, 6'd32);
		write_register(REG_BLACK_RUN_THRESHOLD, 6'd0);
		send_colour(rgba(0, 0, 0, 5));
	endtask

	// Random traffic in phases, each with its own window, threshold and
	// pacing. The windows and thresholds cycle through the extremes as well
	// as values in between.
	task automatic test_random_traffic();
		int unsigned           phase;
		int unsigned           n;
		logic [CFG_DATA_W-1:0] win;
		logic [CFG_DATA_W-1:0] thr;
		for (phase = 0; phase < 13; phase++) begin
			case (phase % 7)
				0: win = 6'd63;
				1: win = 6'd0;
				2: win = 6'd32;
				3: win = 6'd1;
				4: win = 6'd33;
				default: win = CFG_DATA_W'($urandom_range(2, 31));
			endcase
			case (phase % 5)
				0: thr = 6'd0;
				1: thr = 6'd63;
				2: thr = CFG_DATA_W'($urandom_range(1, 4));
				default: thr = CFG_DATA_W'($urandom_range(0, 33));
			endcase
			write_register(REG_WINDOW_LENGTH, win);
			write_register(REG_BLACK_RUN_THRESHOLD, thr);
			tx_steady = (phase % 4 == 1) || (phase % 4 == 3);
			rx_steady = (phase % 4 == 1);
			black_run_left = 0;
			for (n = 0; n < 150; n++)
				send_colour(next_random_colour());
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Stops the input, collects what is still owed, allows the block's
	// latency for anything stray, then gives the verdict.
	task automatic finish_run();
		int unsigned waited;
		pick_ch.valid <= 1'b0;
		waited = 0;
		while (pending_avgs.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		if (pending_avgs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_avgs.size()));
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	endtask

	initial begin
		// Every input of the block is known from time zero.
		pick_ch.valid     = 1'b0;
		pick_ch.new_red   = '0;
		pick_ch.new_green = '0;
		pick_ch.new_blue  = '0;
		pick_ch.new_alpha = '0;
		avg_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		arst_n            = 1'b0;

		// The predictor starts from the reset state of the block.
		for (int i = 0; i < MAX_HISTORY_DEF; i++)
			hist_rgb[i] = '0;
		hist_fill      = 0;
		window_reg     = WINDOW_LENGTH_RST;
		black_thr_reg  = BLACK_RUN_THRESHOLD_RST;
		mismatches     = 0;
		burst_left     = 0;
		tx_steady      = 1'b0;
		rx_steady      = 1'b0;
		rx_on          = 1'b0;
		rx_seg_left    = 0;
		black_run_left = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_channel_extremes();
		test_zero_count();
		test_black_runs();
		test_window_limits();
		test_random_traffic();
		finish_run();
	end

endmodule
